### hdl/cse_pkg.sv
// ----------------------------------------------------------------------------
// cse_pkg
// shared constants and controller/datapath interface types
// ----------------------------------------------------------------------------
package cse_pkg;

    localparam int MAX_LEVELS = 32;
    localparam int FRAC_BITS  = 16;
    localparam int WORD_W     = 32;
    localparam int DIV_W      = WORD_W + 1;
    localparam int ACC_W      = DIV_W + $clog2(MAX_LEVELS);
    localparam int LVL_W      = $clog2(MAX_LEVELS);
    localparam int CNT_W      = 6;
    localparam int IDX_W      = 2;

    localparam logic [WORD_W-1:0] LEVEL_MIN_RST   = 32'sd0;
    localparam logic [WORD_W-1:0] LEVEL_MAX_RST   = 32'sd65536;
    localparam logic [CNT_W-1:0]  LEVEL_COUNT_RST = 6'd10;

    localparam logic [IDX_W-1:0] REG_LEVEL_MIN   = 2'd0;
    localparam logic [IDX_W-1:0] REG_LEVEL_MAX   = 2'd1;
    localparam logic [IDX_W-1:0] REG_LEVEL_COUNT = 2'd2;

    typedef struct packed {
        logic load_cell;
        logic div_start;
        logic div_frac;
        logic q_load;
        logic tri_init;
        logic lvl_start;
        logic edge_next;
        logic lerp_mul;
        logic lerp_add;
        logic lvl_next;
        logic emit;
        logic tri_next;
        logic flush;
    } cmd_t;

    typedef struct packed {
        logic range_ok;
        logic div_done;
        logic lvl_ok;
        logic edge_hit;
        logic edge_last;
        logic hits_two;
        logic tri_upper;
    } stat_t;

endpackage

### hdl/cse_div.sv
// ----------------------------------------------------------------------------
// cse_div
// radix-2 restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module cse_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [cse_pkg::DIV_W-1:0]     rem0,
    input  logic [cse_pkg::DIV_W-1:0]     dividend,
    input  logic [cse_pkg::DIV_W-1:0]     divisor,
    input  logic [cse_pkg::CNT_W-1:0]     iters,
    output logic                          done,
    output logic [cse_pkg::DIV_W-1:0]     quotient,
    output logic [cse_pkg::DIV_W-1:0]     remainder
);

    logic [cse_pkg::DIV_W-1:0] rem_reg, rem_next;
    logic [cse_pkg::DIV_W-1:0] dvd_reg, dvd_next;
    logic [cse_pkg::DIV_W-1:0] dvs_reg, dvs_next;
    logic [cse_pkg::DIV_W-1:0] quo_reg, quo_next;
    logic [cse_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                      run_reg, run_next;
    logic                      done_reg, done_next;
    logic [cse_pkg::DIV_W:0]   trial;
    logic [cse_pkg::DIV_W:0]   diff;
    logic                      ge;

    assign trial = {rem_reg, dvd_reg[cse_pkg::DIV_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign ge    = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = rem0;
            dvd_next = dividend;
            dvs_next = divisor;
            quo_next = '0;
            cnt_next = iters;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            rem_next = ge ? diff[cse_pkg::DIV_W-1:0] : trial[cse_pkg::DIV_W-1:0];
            dvd_next = {dvd_reg[cse_pkg::DIV_W-2:0], 1'b0};
            quo_next = {quo_reg[cse_pkg::DIV_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == cse_pkg::CNT_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

### hdl/cse_datapath.sv
// ----------------------------------------------------------------------------
// cse_datapath
// config registers, cell storage, level stepping, edge crossing and lerp
// ----------------------------------------------------------------------------
module cse_datapath (
    input  logic                      clk,
    input  logic                      rst_n,
    input  cse_pkg::cmd_t             cmd,
    output cse_pkg::stat_t            stat,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [cse_pkg::IDX_W-1:0] cfg_index,
    input  logic [31:0]               cfg_data,
    input  logic signed [31:0]        x_bl,
    input  logic signed [31:0]        y_bl,
    input  logic signed [31:0]        v_bl,
    input  logic signed [31:0]        x_br,
    input  logic signed [31:0]        y_br,
    input  logic signed [31:0]        v_br,
    input  logic signed [31:0]        x_tr,
    input  logic signed [31:0]        y_tr,
    input  logic signed [31:0]        v_tr,
    input  logic signed [31:0]        x_tl,
    input  logic signed [31:0]        y_tl,
    input  logic signed [31:0]        v_tl,
    output logic                      seg_valid,
    output logic signed [31:0]        seg_x0,
    output logic signed [31:0]        seg_y0,
    output logic signed [31:0]        seg_x1,
    output logic signed [31:0]        seg_y1,
    output logic [4:0]                level_index,
    output logic                      upper_triangle,
    output logic                      last_segment
);

    localparam int DW = cse_pkg::DIV_W;
    localparam int AW = cse_pkg::ACC_W;
    localparam int LW = cse_pkg::LVL_W;
    localparam int FB = cse_pkg::FRAC_BITS;
    localparam int PW = DW + FB + 1;

    // configuration
    logic signed [31:0] min_reg, max_reg;
    logic [cse_pkg::CNT_W-1:0] cnt_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= cse_pkg::LEVEL_MIN_RST;
            max_reg <= cse_pkg::LEVEL_MAX_RST;
            cnt_reg <= cse_pkg::LEVEL_COUNT_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                cse_pkg::REG_LEVEL_MIN:   min_reg <= cfg_data;
                cse_pkg::REG_LEVEL_MAX:   max_reg <= cfg_data;
                cse_pkg::REG_LEVEL_COUNT: cnt_reg <= cfg_data[cse_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    logic signed [DW-1:0] diff_s;
    logic [DW-1:0]        diff_u;
    logic [LW-1:0]        n1;

    assign diff_s = DW'(max_reg) - DW'(min_reg);
    assign diff_u = diff_s;

    always_comb
    begin
        if (cnt_reg < cse_pkg::CNT_W'(2))
            n1 = LW'(1);
        else if (cnt_reg > cse_pkg::CNT_W'(cse_pkg::MAX_LEVELS))
            n1 = LW'(cse_pkg::MAX_LEVELS - 1);
        else
            n1 = LW'(cnt_reg - 1'b1);
    end

    // cell corners, index 0 bl, 1 br, 2 tr, 3 tl
    logic signed [31:0] cx_reg [4];
    logic signed [31:0] cy_reg [4];
    logic signed [31:0] cv_reg [4];
    logic               tri_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_cell)
        begin
            cx_reg[0] <= x_bl; cy_reg[0] <= y_bl; cv_reg[0] <= v_bl;
            cx_reg[1] <= x_br; cy_reg[1] <= y_br; cv_reg[1] <= v_br;
            cx_reg[2] <= x_tr; cy_reg[2] <= y_tr; cv_reg[2] <= v_tr;
            cx_reg[3] <= x_tl; cy_reg[3] <= y_tl; cv_reg[3] <= v_tl;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tri_reg <= 1'b0;
        else if (cmd.load_cell)
            tri_reg <= 1'b0;
        else if (cmd.tri_next)
            tri_reg <= 1'b1;
    end

    // triangle corners
    logic signed [31:0] p0x, p0y, p0v, p1x, p1y, p1v, p2x, p2y, p2v;

    assign p0x = tri_reg ? cx_reg[1] : cx_reg[0];
    assign p0y = tri_reg ? cy_reg[1] : cy_reg[0];
    assign p0v = tri_reg ? cv_reg[1] : cv_reg[0];
    assign p1x = tri_reg ? cx_reg[2] : cx_reg[1];
    assign p1y = tri_reg ? cy_reg[2] : cy_reg[1];
    assign p1v = tri_reg ? cv_reg[2] : cv_reg[1];
    assign p2x = cx_reg[3];
    assign p2y = cy_reg[3];
    assign p2v = cv_reg[3];

    logic signed [31:0]   vmax01, vmax;
    logic signed [DW-1:0] vspan;
    logic [AW-1:0]        vm_reg;
    logic                 vneg_reg;

    assign vmax01 = (p1v > p0v) ? p1v : p0v;
    assign vmax   = (p2v > vmax01) ? p2v : vmax01;
    assign vspan  = DW'(vmax) - DW'(min_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.tri_init)
        begin
            vneg_reg <= vspan[DW-1];
            vm_reg   <= AW'(vspan[DW-2:0]) * AW'(n1);
        end
    end

    // level stepping: level c is min + floor(diff*c/n1)
    logic [DW-1:0]    step_q_reg;
    logic [LW-1:0]    step_r_reg;
    logic [LW:0]      c_reg;
    logic [DW-1:0]    q_reg;
    logic [LW-1:0]    r_reg;
    logic [AW-1:0]    cdiff_reg;
    logic [LW:0]      r_sum;
    logic signed [31:0] lev_reg;
    logic [DW-1:0]    quo, rem;
    logic             div_done;

    assign r_sum = {1'b0, r_reg} + {1'b0, step_r_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.q_load)
        begin
            step_q_reg <= quo;
            step_r_reg <= rem[LW-1:0];
        end
        if (cmd.tri_init)
        begin
            c_reg     <= '0;
            q_reg     <= '0;
            r_reg     <= '0;
            cdiff_reg <= '0;
        end
        else if (cmd.lvl_next)
        begin
            c_reg     <= c_reg + 1'b1;
            cdiff_reg <= cdiff_reg + AW'(diff_u);
            if (r_sum >= {1'b0, n1})
            begin
                r_reg <= LW'(r_sum - {1'b0, n1});
                q_reg <= q_reg + step_q_reg + 1'b1;
            end
            else
            begin
                r_reg <= r_sum[LW-1:0];
                q_reg <= q_reg + step_q_reg;
            end
        end
        if (cmd.lvl_start)
            lev_reg <= min_reg + q_reg[31:0];
    end

    // edge crossing
    logic [1:0]         edge_reg;
    logic [1:0]         hits_reg;
    logic signed [31:0] ax, ay, av, bx, by, bv;
    logic signed [DW:0] num, den, num_a, den_a;
    logic               hit;

    always_comb
    begin
        case (edge_reg)
            2'd0:
            begin
                ax = p0x; ay = p0y; av = p0v; bx = p1x; by = p1y; bv = p1v;
            end
            2'd1:
            begin
                ax = p1x; ay = p1y; av = p1v; bx = p2x; by = p2y; bv = p2v;
            end
            default:
            begin
                ax = p2x; ay = p2y; av = p2v; bx = p0x; by = p0y; bv = p0v;
            end
        endcase
    end

    assign num   = (DW+1)'(lev_reg) - (DW+1)'(av);
    assign den   = (DW+1)'(bv) - (DW+1)'(av);
    assign num_a = den[DW] ? -num : num;
    assign den_a = den[DW] ? -den : den;
    assign hit   = (num_a > 0) && (num_a < den_a);

    always_ff @(posedge clk)
    begin
        if (cmd.lvl_start)
            edge_reg <= '0;
        else if (cmd.edge_next)
            edge_reg <= edge_reg + 1'b1;
    end

    // shared divider: level step once per cell, crossing fraction per hit edge
    cse_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .rem0      (cmd.div_frac ? num_a[DW-1:0] : '0),
        .dividend  (cmd.div_frac ? '0 : diff_u),
        .divisor   (cmd.div_frac ? den_a[DW-1:0] : DW'(n1)),
        .iters     (cmd.div_frac ? cse_pkg::CNT_W'(FB) : cse_pkg::CNT_W'(DW)),
        .done      (div_done),
        .quotient  (quo),
        .remainder (rem)
    );

    // interpolation
    logic signed [PW-1:0] f_s;
    logic signed [PW-1:0] dx, dy;
    logic signed [PW-1:0] prodx_reg, prody_reg;
    logic signed [31:0]   ex_new, ey_new;
    logic signed [31:0]   ex0_reg, ey0_reg, ex1_reg, ey1_reg;

    assign f_s = PW'(quo[FB-1:0]);
    assign dx  = PW'(bx) - PW'(ax);
    assign dy  = PW'(by) - PW'(ay);

    assign ex_new = ax + 32'(prodx_reg >>> FB);
    assign ey_new = ay + 32'(prody_reg >>> FB);

    always_ff @(posedge clk)
    begin
        if (cmd.lerp_mul)
        begin
            prodx_reg <= dx * f_s;
            prody_reg <= dy * f_s;
        end
        if (cmd.lerp_add)
        begin
            if (hits_reg == 2'd0)
            begin
                ex0_reg <= ex_new;
                ey0_reg <= ey_new;
            end
            else if (hits_reg == 2'd1)
            begin
                ex1_reg <= ex_new;
                ey1_reg <= ey_new;
            end
        end
        if (cmd.lvl_start)
            hits_reg <= '0;
        else if (cmd.lerp_add && hits_reg != 2'd3)
            hits_reg <= hits_reg + 1'b1;
    end

    // one segment held back so the final one can carry the last flag
    logic                pend_v_reg;
    logic signed [31:0]  pend_x0_reg, pend_y0_reg, pend_x1_reg, pend_y1_reg;
    logic [4:0]          pend_lvl_reg;
    logic                pend_up_reg;
    logic                out_v_reg;
    logic signed [31:0]  out_x0_reg, out_y0_reg, out_x1_reg, out_y1_reg;
    logic [4:0]          out_lvl_reg;
    logic                out_up_reg, out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            out_v_reg <= (cmd.emit || cmd.flush) && pend_v_reg;
            if (cmd.emit)
                pend_v_reg <= 1'b1;
            else if (cmd.flush)
                pend_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit || cmd.flush)
        begin
            out_x0_reg   <= pend_x0_reg;
            out_y0_reg   <= pend_y0_reg;
            out_x1_reg   <= pend_x1_reg;
            out_y1_reg   <= pend_y1_reg;
            out_lvl_reg  <= pend_lvl_reg;
            out_up_reg   <= pend_up_reg;
            out_last_reg <= cmd.flush;
        end
        if (cmd.emit)
        begin
            pend_x0_reg  <= ex0_reg;
            pend_y0_reg  <= ey0_reg;
            pend_x1_reg  <= ex1_reg;
            pend_y1_reg  <= ey1_reg;
            pend_lvl_reg <= c_reg[4:0];
            pend_up_reg  <= tri_reg;
        end
    end

    assign seg_valid      = out_v_reg;
    assign seg_x0         = out_x0_reg;
    assign seg_y0         = out_y0_reg;
    assign seg_x1         = out_x1_reg;
    assign seg_y1         = out_y1_reg;
    assign level_index    = out_lvl_reg;
    assign upper_triangle = out_up_reg;
    assign last_segment   = out_last_reg;

    assign stat.range_ok  = diff_s > 0;
    assign stat.div_done  = div_done;
    assign stat.lvl_ok    = !vneg_reg && (c_reg <= {1'b0, n1}) && (cdiff_reg <= vm_reg);
    assign stat.edge_hit  = hit;
    assign stat.edge_last = edge_reg == 2'd2;
    assign stat.hits_two  = hits_reg == 2'd2;
    assign stat.tri_upper = tri_reg;

endmodule

### hdl/cse_ctrl.sv
// ----------------------------------------------------------------------------
// cse_ctrl
// sequencer over triangles, levels and edges
// ----------------------------------------------------------------------------
module cse_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  cse_pkg::stat_t stat,
    output cse_pkg::cmd_t  cmd
);

    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_DIVQ = 11'b000_0000_0010,
        S_TRI  = 11'b000_0000_0100,
        S_LCHK = 11'b000_0000_1000,
        S_EDGE = 11'b000_0001_0000,
        S_EDIV = 11'b000_0010_0000,
        S_LMUL = 11'b000_0100_0000,
        S_LADD = 11'b000_1000_0000,
        S_LEND = 11'b001_0000_0000,
        S_TNXT = 11'b010_0000_0000,
        S_FLSH = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load_cell = 1'b1;
                    if (stat.range_ok)
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = S_DIVQ;
                    end
                end
            end
            S_DIVQ:
            begin
                if (stat.div_done)
                begin
                    cmd.q_load = 1'b1;
                    state_next = S_TRI;
                end
            end
            S_TRI:
            begin
                cmd.tri_init = 1'b1;
                state_next   = S_LCHK;
            end
            S_LCHK:
            begin
                if (stat.lvl_ok)
                begin
                    cmd.lvl_start = 1'b1;
                    state_next    = S_EDGE;
                end
                else
                    state_next = S_TNXT;
            end
            S_EDGE:
            begin
                if (stat.edge_hit)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_frac  = 1'b1;
                    state_next    = S_EDIV;
                end
                else if (stat.edge_last)
                    state_next = S_LEND;
                else
                    cmd.edge_next = 1'b1;
            end
            S_EDIV:
            begin
                if (stat.div_done)
                begin
                    cmd.lerp_mul = 1'b1;
                    state_next   = S_LMUL;
                end
            end
            S_LMUL:
            begin
                state_next = S_LADD;
            end
            S_LADD:
            begin
                cmd.lerp_add  = 1'b1;
                cmd.edge_next = 1'b1;
                state_next    = stat.edge_last ? S_LEND : S_EDGE;
            end
            S_LEND:
            begin
                cmd.emit     = stat.hits_two;
                cmd.lvl_next = 1'b1;
                state_next   = S_LCHK;
            end
            S_TNXT:
            begin
                if (stat.tri_upper)
                    state_next = S_FLSH;
                else
                begin
                    cmd.tri_next = 1'b1;
                    state_next   = S_TRI;
                end
            end
            S_FLSH:
            begin
                cmd.flush  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = state_reg != S_IDLE;

endmodule

### hdl/contour_segment_extractor.sv
// ----------------------------------------------------------------------------
// contour_segment_extractor
// marching triangles isoline segments for one grid cell per command
// ----------------------------------------------------------------------------
// sequence: the level step division after the start word, then per triangle a setup
//   state, per level a check, one state per edge and an end state, and per crossed
//   edge the shared divider, multiply and add, then a flush before the final word
// throughput: one cell at a time, busy until the final segment is issued
// each segment is strobed on seg_valid for one cycle; the receiver cannot stall
// reset: levels return to 0, 1.0 and 10, no cell in flight
module contour_segment_extractor (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [cse_pkg::IDX_W-1:0] cfg_index,
    input  logic [31:0]               cfg_data,
    input  logic signed [31:0]        x_bl,
    input  logic signed [31:0]        y_bl,
    input  logic signed [31:0]        v_bl,
    input  logic signed [31:0]        x_br,
    input  logic signed [31:0]        y_br,
    input  logic signed [31:0]        v_br,
    input  logic signed [31:0]        x_tr,
    input  logic signed [31:0]        y_tr,
    input  logic signed [31:0]        v_tr,
    input  logic signed [31:0]        x_tl,
    input  logic signed [31:0]        y_tl,
    input  logic signed [31:0]        v_tl,
    output logic                      seg_valid,
    output logic signed [31:0]        seg_x0,
    output logic signed [31:0]        seg_y0,
    output logic signed [31:0]        seg_x1,
    output logic signed [31:0]        seg_y1,
    output logic [4:0]                level_index,
    output logic                      upper_triangle,
    output logic                      last_segment
);

    cse_pkg::cmd_t  cmd;
    cse_pkg::stat_t stat;

    cse_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    cse_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .x_bl           (x_bl),
        .y_bl           (y_bl),
        .v_bl           (v_bl),
        .x_br           (x_br),
        .y_br           (y_br),
        .v_br           (v_br),
        .x_tr           (x_tr),
        .y_tr           (y_tr),
        .v_tr           (v_tr),
        .x_tl           (x_tl),
        .y_tl           (y_tl),
        .v_tl           (v_tl),
        .seg_valid      (seg_valid),
        .seg_x0         (seg_x0),
        .seg_y0         (seg_y0),
        .seg_x1         (seg_x1),
        .seg_y1         (seg_y1),
        .level_index    (level_index),
        .upper_triangle (upper_triangle),
        .last_segment   (last_segment)
    );

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for contour_segment_extractor: directed and random grid
// cells across several level settings, with every segment word compared
// against an in-bench isoline predictor
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WD_LIMIT = 20000;

    typedef struct {
        logic signed [31:0] x[4];
        logic signed [31:0] y[4];
        logic signed [31:0] v[4];
    } cell_t;

    typedef struct {
        logic signed [31:0] x0, y0, x1, y1;
        logic [4:0]         lvl;
        logic               upper;
        logic               last;
    } seg_t;

    logic clk, rst_n, start, busy, cfg_valid, cfg_ready;
    logic [cse_pkg::IDX_W-1:0] cfg_index;
    logic [31:0] cfg_data;
    logic signed [31:0] x_bl, y_bl, v_bl, x_br, y_br, v_br;
    logic signed [31:0] x_tr, y_tr, v_tr, x_tl, y_tl, v_tl;
    logic seg_valid, upper_triangle, last_segment;
    logic signed [31:0] seg_x0, seg_y0, seg_x1, seg_y1;
    logic [4:0] level_index;

    contour_segment_extractor DUT (.*);

    cell_t cell_pending[$];
    seg_t  seg_expected[$];
    logic [31:0] lvl_min_r, lvl_max_r;
    logic [5:0]  lvl_cnt_r;
    int errors, cells_done, segs_seen, wd_count;
    bit idle_on;

    initial clk = 1'b0;
    always #6 clk = ~clk;

    task automatic report(string msg);
        errors++;
        $display("mismatch @%0t: %s", $realtime, msg);
    endtask

    function automatic void predict_segments(cell_t cl);
        int tri_corner[2][3] = '{'{0, 1, 3}, '{1, 2, 3}};
        longint lmin, lmax, diff, n, vmax, cend, lev, num, den, f;
        longint px[3], py[3], pv[3], ex[2], ey[2];
        int hits, made, b;
        seg_t s;
        lmin = longint'($signed(lvl_min_r));
        lmax = longint'($signed(lvl_max_r));
        made = 0;
        if (lmax <= lmin)
            return;
        n = lvl_cnt_r;
        if (n < 2) n = 2;
        if (n > cse_pkg::MAX_LEVELS) n = cse_pkg::MAX_LEVELS;
        diff = lmax - lmin;
        for (int t = 0; t < 2; t++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                px[k] = cl.x[tri_corner[t][k]];
                py[k] = cl.y[tri_corner[t][k]];
                pv[k] = cl.v[tri_corner[t][k]];
            end
            vmax = pv[0];
            if (pv[1] > vmax) vmax = pv[1];
            if (pv[2] > vmax) vmax = pv[2];
            if (vmax < lmin)
                continue;
            cend = ((vmax - lmin) * (n - 1)) / diff;
            if (cend > n - 1) cend = n - 1;
            for (longint c = 0; c <= cend; c++)
            begin
                lev = lmin + (diff * c) / (n - 1);
                hits = 0;
                for (int k = 0; k < 3; k++)
                begin
                    b = (k + 1) % 3;
                    num = lev - pv[k];
                    den = pv[b] - pv[k];
                    if (den < 0)
                    begin
                        num = -num;
                        den = -den;
                    end
                    if (num > 0 && num < den)
                    begin
                        f = (num << cse_pkg::FRAC_BITS) / den;
                        if (hits < 2)
                        begin
                            ex[hits] = px[k] + (((px[b] - px[k]) * f) >>> cse_pkg::FRAC_BITS);
                            ey[hits] = py[k] + (((py[b] - py[k]) * f) >>> cse_pkg::FRAC_BITS);
                        end
                        hits++;
                    end
                end
                if (hits == 2 && made < 2 * cse_pkg::MAX_LEVELS)
                begin
                    s.x0 = ex[0][31:0];
                    s.y0 = ey[0][31:0];
                    s.x1 = ex[1][31:0];
                    s.y1 = ey[1][31:0];
                    s.lvl = c[4:0];
                    s.upper = t[0];
                    s.last = 1'b0;
                    seg_expected.push_back(s);
                    made++;
                end
            end
        end
        if (made > 0)
            seg_expected[seg_expected.size() - 1].last = 1'b1;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        cell_t cl;
        if (!rst_n)
        begin
            start <= 1'b0;
            {x_bl, y_bl, v_bl, x_br, y_br, v_br} <= '0;
            {x_tr, y_tr, v_tr, x_tl, y_tl, v_tl} <= '0;
        end
        else if (!start || !busy)
        begin
            if (start)
                cells_done++;
            if (cell_pending.size() > 0 && !(idle_on && $urandom_range(99) < 38))
            begin
                cl = cell_pending.pop_front();
                predict_segments(cl);
                start <= 1'b1;
                x_bl <= cl.x[0]; y_bl <= cl.y[0]; v_bl <= cl.v[0];
                x_br <= cl.x[1]; y_br <= cl.y[1]; v_br <= cl.v[1];
                x_tr <= cl.x[2]; y_tr <= cl.y[2]; v_tr <= cl.v[2];
                x_tl <= cl.x[3]; y_tl <= cl.y[3]; v_tl <= cl.v[3];
            end
            else
                start <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        seg_t e;
        if (rst_n && seg_valid)
        begin
            segs_seen++;
            if (seg_expected.size() == 0)
                report("segment word with nothing expected");
            else
            begin
                e = seg_expected.pop_front();
                if (seg_x0 !== e.x0) report($sformatf("seg_x0 %h exp %h", seg_x0, e.x0));
                if (seg_y0 !== e.y0) report($sformatf("seg_y0 %h exp %h", seg_y0, e.y0));
                if (seg_x1 !== e.x1) report($sformatf("seg_x1 %h exp %h", seg_x1, e.x1));
                if (seg_y1 !== e.y1) report($sformatf("seg_y1 %h exp %h", seg_y1, e.y1));
                if (level_index !== e.lvl)
                    report($sformatf("level_index %0d exp %0d", level_index, e.lvl));
                if (upper_triangle !== e.upper)
                    report($sformatf("upper_triangle %b exp %b", upper_triangle, e.upper));
                if (last_segment !== e.last)
                    report($sformatf("last_segment %b exp %b", last_segment, e.last));
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (!rst_n || seg_valid || (start && !busy) || (cfg_valid && cfg_ready))
            wd_count <= 0;
        else
        begin
            wd_count <= wd_count + 1;
            if (wd_count >= WD_LIMIT)
            begin
                $display("timeout, %0d segment words outstanding", seg_expected.size());
                $display("FAIL contour_segment_extractor");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [cse_pkg::IDX_W-1:0] idx, logic [31:0] d);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(negedge clk);
        while (!cfg_ready)
            @(negedge clk);
        @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            cse_pkg::REG_LEVEL_MIN:   lvl_min_r = d;
            cse_pkg::REG_LEVEL_MAX:   lvl_max_r = d;
            cse_pkg::REG_LEVEL_COUNT: lvl_cnt_r = d[5:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        @(negedge clk);
        while (cell_pending.size() > 0 || start || busy || seg_expected.size() > 0)
            @(negedge clk);
        repeat (40) @(posedge clk);
    endtask

    function automatic logic signed [31:0] clip32(longint v);
        if (v > 64'sh7fffffff) return 32'sh7fffffff;
        if (v < -64'sh80000000) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic cell_t square_cell(longint x0, longint y0, longint stp,
                                          longint v0, longint v1, longint v2, longint v3);
        cell_t cl;
        cl.x[0] = clip32(x0);       cl.y[0] = clip32(y0);
        cl.x[1] = clip32(x0 + stp); cl.y[1] = clip32(y0);
        cl.x[2] = clip32(x0 + stp); cl.y[2] = clip32(y0 + stp);
        cl.x[3] = clip32(x0);       cl.y[3] = clip32(y0 + stp);
        cl.v[0] = clip32(v0); cl.v[1] = clip32(v1);
        cl.v[2] = clip32(v2); cl.v[3] = clip32(v3);
        return cl;
    endfunction

    function automatic cell_t random_cell();
        cell_t cl;
        longint lmin, diff, span, stp, n;
        lmin = longint'($signed(lvl_min_r));
        diff = longint'($signed(lvl_max_r)) - lmin;
        if (diff < 1) diff = 65536;
        if ($urandom_range(99) < 20)
        begin
            for (int k = 0; k < 4; k++)
            begin
                cl.x[k] = $urandom; cl.y[k] = $urandom; cl.v[k] = $urandom;
            end
            return cl;
        end
        stp = $urandom_range(1, 1 << $urandom_range(1, 24));
        if ($urandom_range(1)) stp = -stp;
        cl = square_cell(longint'($signed($urandom)), longint'($signed($urandom)), stp,
                         0, 0, 0, 0);
        span = diff + diff / 4 + 1;
        n = lvl_cnt_r < 2 ? 2 :
            (lvl_cnt_r > cse_pkg::MAX_LEVELS ? cse_pkg::MAX_LEVELS : lvl_cnt_r);
        for (int k = 0; k < 4; k++)
        begin
            if ($urandom_range(9) == 0)
                cl.v[k] = clip32(lmin + (diff * $urandom_range(n - 1)) / (n - 1));
            else
                cl.v[k] = clip32(lmin - diff / 8 + longint'({$urandom, $urandom} % span));
        end
        return cl;
    endfunction

    initial
    begin
        logic [31:0] p_min[9] = '{32'h0, 32'h80000000, 32'hffff0000, 32'd100000,
                                  32'd65536, 32'h0, 32'hfffb0000, 32'd12345, 32'h0};
        logic [31:0] p_max[9] = '{32'd65536, 32'h7fffffff, 32'd65536, 32'd100000,
                                  32'd32768, 32'd196608, 32'd327680, 32'd12352, 32'd65536};
        logic [5:0]  p_cnt[9] = '{6'd10, 6'd32, 6'd0, 6'd5, 6'd7, 6'd1, 6'd63, 6'd2, 6'd33};
        int n_rand;
        rst_n = 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= cse_pkg::REG_LEVEL_MIN;
        cfg_data  <= '0;
        lvl_min_r = cse_pkg::LEVEL_MIN_RST;
        lvl_max_r = cse_pkg::LEVEL_MAX_RST;
        lvl_cnt_r = cse_pkg::LEVEL_COUNT_RST;
        errors = 0; cells_done = 0; segs_seen = 0;
        idle_on = 1'b1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        for (int p = 0; p < 9; p++)
        begin
            if (p > 0)
            begin
                drain();
                write_reg(cse_pkg::REG_LEVEL_MIN, p_min[p]);
                write_reg(cse_pkg::REG_LEVEL_MAX, p_max[p]);
                write_reg(cse_pkg::REG_LEVEL_COUNT, {26'd0, p_cnt[p]});
            end
            idle_on = (p != 2);
            if (p == 0)
            begin
                cell_pending.push_back(square_cell(-64'sh80000000, 64'sh7fffffff, 0,
                    -64'sh80000000, 64'sh7fffffff, -64'sh80000000, 64'sh7fffffff));
                cell_pending.push_back(square_cell(64'sh7fff0000, -64'sh80000000, 65535,
                    0, 65536, 65536, 0));
                cell_pending.push_back(square_cell(0, 0, 65536, 32768, 32768, 32768, 32768));
                cell_pending.push_back(square_cell(0, 0, 65536, 0, 65536, 65536, 0));
                cell_pending.push_back(square_cell(100, -100, 4096, -5, -5, 65536, -5));
                cell_pending.push_back(square_cell(0, 0, 65536, -65536, -65536, -65536, -1));
                cell_pending.push_back(square_cell(0, 0, 65536,
                    131072, 131072, 131072, 131072));
                cell_pending.push_back(square_cell(-65536, -65536, -65536, 0, 65536, 0, 65536));
                cell_pending.push_back(square_cell(12, 34, 1, 65535, 1, 65536, 0));
                cell_pending.push_back(square_cell(0, 0, 65536, 7281, 14563, 0, 65535));
                cell_pending.push_back(square_cell(-1, -1, 1 << 24,
                    64'sh7fffffff, -64'sh80000000, 0, 65536));
            end
            n_rand = (p == 3 || p == 4) ? 6 : 20;
            for (int i = 0; i < n_rand; i++)
                cell_pending.push_back(random_cell());
        end
        drain();
        repeat (60) @(posedge clk);
        $display("%0d cells over 9 level settings, %0d segment words checked, %0d errors",
                 cells_done, segs_seen, errors);
        if (errors == 0)
            $display("PASS contour_segment_extractor");
        else
            $display("FAIL contour_segment_extractor");
        $finish;
    end

endmodule

### sim.f
hdl/cse_pkg.sv
hdl/cse_div.sv
hdl/cse_datapath.sv
hdl/cse_ctrl.sv
hdl/contour_segment_extractor.sv
tb/tb_top.sv
